// ===== design/rks_pkg.sv =====
package rks_pkg;
	localparam int unsigned Capacity = 1024;
	localparam int unsigned AddrW = $clog2(Capacity);
	localparam int unsigned CountW = $clog2(Capacity + 1);

	typedef logic signed [31:0] data_t;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic [CountW-1:0] count_t;

	typedef enum logic [0:0] {
		CMD_ADD = 1'b0,
		CMD_GET = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_RANK = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_GETRD,
		S_GETWT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic we;
		addr_t waddr;
		data_t wdata;
		addr_t raddr;
	} mem_ctl_t;
endpackage

// ===== design/rks_if.sv =====
interface rks_in_if;
	import rks_pkg::*;
	logic valid;
	logic ready;
	logic command;
	data_t value;
	modport source(output valid, command, value, input ready);
	modport sink(input valid, command, value, output ready);
endinterface

interface rks_out_if;
	import rks_pkg::*;
	logic valid;
	logic ready;
	data_t result_value;
	logic [1:0] status;
	modport source(output valid, result_value, status, input ready);
	modport sink(input valid, result_value, status, output ready);
endinterface

// ===== design/running_kth_smallest_unit.sv =====
// Sorted store of up to 1024 signed words in one synchronous RAM (registered read).
// Add: shifts stored entries greater than the new word up one slot per cycle from the top,
// then writes the new word into the freed slot; produces no output.
// Get, or add to a full store: the result word is valid after states S_GETRD and S_GETWT,
// and the next word is taken no earlier than the cycle after the result is taken.
// One word is in work at a time; reset clears count to 0 and rank to 1, RAM is not cleared.
module running_kth_smallest_unit (
	input logic clk,
	input logic arst_n,
	rks_in_if.sink in_ch,
	rks_out_if.source out_ch
);
	import rks_pkg::*;

	state_t state_q, state_d;
	count_t count_q, rank_q, pos_q;
	data_t val_q, res_q, rdata;
	logic [1:0] st_q;
	mem_ctl_t ctl;
	logic full;

	rks_mem u_mem (.clk(clk), .ctl(ctl), .rdata(rdata));

	assign full = (count_q == count_t'(Capacity));
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.result_value = res_q;
	assign out_ch.status = st_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.command == CMD_GET || full) begin
						state_d = S_GETRD;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (pos_q == '0 || !(rdata > val_q)) begin
					state_d = S_IDLE;
				end
			end
			S_GETRD: state_d = S_GETWT;
			S_GETWT: state_d = S_OUT;
			S_OUT: begin
				if (out_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.we = 1'b0;
		ctl.waddr = pos_q[AddrW-1:0];
		ctl.wdata = val_q;
		ctl.raddr = '0;
		case (state_q)
			S_IDLE: begin
				ctl.raddr = addr_t'(count_q - count_t'(1));
			end
			S_SCAN: begin
				ctl.we = 1'b1;
				if (pos_q != '0 && rdata > val_q) begin
					ctl.wdata = rdata;
				end
				ctl.raddr = addr_t'(pos_q - count_t'(2));
			end
			S_GETRD: ctl.raddr = addr_t'(rank_q - count_t'(1));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rank_q <= count_t'(1);
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN && state_d == S_IDLE) begin
				count_q <= count_q + count_t'(1);
			end
			if (state_q == S_GETWT && val_q[0] && rank_q <= count_q) begin
				rank_q <= rank_q + count_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pos_q <= count_q;
				val_q <= in_ch.value;
				if (in_ch.command == CMD_GET) begin
					val_q <= data_t'(1);
				end else if (full) begin
					val_q <= '0;
				end
			end
			S_SCAN: pos_q <= pos_q - count_t'(1);
			S_GETWT: begin
				if (!val_q[0]) begin
					res_q <= '0;
					st_q <= ST_FULL;
				end else if (rank_q == '0 || rank_q > count_q) begin
					res_q <= '0;
					st_q <= ST_RANK;
				end else begin
					res_q <= rdata;
					st_q <= ST_OK;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== design/rks_mem.sv =====
module rks_mem (
	input logic clk,
	input rks_pkg::mem_ctl_t ctl,
	output rks_pkg::data_t rdata
);
	import rks_pkg::*;

	data_t mem [Capacity];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata <= mem[ctl.raddr];
	end
endmodule

// ===== sim/running_kth_smallest_unit_tb.sv =====
`timescale 1ns / 1ps

module running_kth_smallest_unit_tb;
	import rks_pkg::*;

	typedef struct {
		cmd_t cmd;
		data_t val;
	} word_t;

	typedef struct {
		data_t val;
		status_t st;
	} answer_t;

	localparam int unsigned CycleLimit = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rks_in_if in_ch();
	rks_out_if out_ch();

	running_kth_smallest_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	word_t pending[$];
	answer_t answers_due[$];
	data_t sorted_store[$];
	int unsigned next_rank = 1;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned hold_left = 0;
	logic hold_go = 1'b0;
	int unsigned cycles = 0;
	int unsigned errors = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Inserts after equal values; a get beyond the stored count leaves the rank alone.
	task automatic apply_word(input word_t w);
		answer_t a;
		int pos;
		if (w.cmd == CMD_ADD) begin
			if (sorted_store.size() >= Capacity) begin
				a.val = '0;
				a.st = ST_FULL;
				answers_due.push_back(a);
			end else begin
				pos = sorted_store.size();
				while (pos > 0 && sorted_store[pos-1] > w.val)
					pos--;
				sorted_store.insert(pos, w.val);
			end
		end else begin
			if (next_rank > sorted_store.size()) begin
				a.val = '0;
				a.st = ST_RANK;
			end else begin
				a.val = sorted_store[next_rank-1];
				a.st = ST_OK;
				next_rank++;
			end
			answers_due.push_back(a);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= 1'b0;
			in_ch.value <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				w.cmd = cmd_t'(in_ch.command);
				w.val = in_ch.value;
				apply_word(w);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
					w = pending.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.command <= w.cmd;
					in_ch.value <= w.val;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_go && hold_left == 0) begin
			hold_left <= 400;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		answer_t a;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (answers_due.size() == 0) begin
				$error("unexpected result word: result_value %0d status %0d",
					out_ch.result_value, out_ch.status);
				errors++;
			end else begin
				a = answers_due.pop_front();
				if (out_ch.result_value !== a.val) begin
					$error("result_value: expected %0d, got %0d", a.val, out_ch.result_value);
					errors++;
				end
				if (out_ch.status !== a.st) begin
					$error("status: expected %0d, got %0d", a.st, out_ch.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("running_kth_smallest_unit regression: fail");
			$finish;
		end
	end

	function automatic word_t make_word(input cmd_t c, input data_t v);
		word_t w;
		w.cmd = c;
		w.val = v;
		return w;
	endfunction

	function automatic word_t random_word();
		data_t v;
		case ($urandom_range(3))
			0: v = data_t'($urandom_range(16)) - 8;
			1: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: v = data_t'($urandom);
		endcase
		return make_word($urandom_range(99) < 55 ? CMD_ADD : CMD_GET, v);
	endfunction

	task automatic drain();
		while (pending.size() > 0 || in_ch.valid || answers_due.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = 1'b0;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 10;
		recv_idle = 72;
		pending.push_back(make_word(CMD_GET, 32'sd5));
		pending.push_back(make_word(CMD_ADD, 32'sh7fffffff));
		pending.push_back(make_word(CMD_ADD, 32'sh80000000));
		pending.push_back(make_word(CMD_ADD, 32'sd0));
		pending.push_back(make_word(CMD_ADD, -32'sd1));
		pending.push_back(make_word(CMD_ADD, 32'sd0));
		pending.push_back(make_word(CMD_ADD, 32'sd1));
		pending.push_back(make_word(CMD_GET, 32'sh7fffffff));
		pending.push_back(make_word(CMD_GET, 32'sd0));
		pending.push_back(make_word(CMD_GET, 32'sd0));
		pending.push_back(make_word(CMD_GET, 32'sd0));
		pending.push_back(make_word(CMD_GET, 32'sd0));
		pending.push_back(make_word(CMD_GET, 32'sd0));
		pending.push_back(make_word(CMD_GET, 32'sd0));
		pending.push_back(make_word(CMD_ADD, 32'sh55555555));
		pending.push_back(make_word(CMD_ADD, 32'shaaaaaaaa));
		pending.push_back(make_word(CMD_GET, 32'sd0));
		pending.push_back(make_word(CMD_GET, 32'sd0));
		drain();

		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		for (int i = 0; i < 40; i++)
			pending.push_back(random_word());
		for (int i = 0; i < 180; i++)
			pending.push_back(random_word());
		drain();

		send_idle = 72;
		recv_idle = 10;
		for (int i = 0; i < 220; i++)
			pending.push_back(random_word());
		drain();

		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 190; i++)
			pending.push_back(random_word());
		drain();

		repeat (1100) @(negedge clk);
		if (errors == 0)
			$display("running_kth_smallest_unit regression: pass");
		else
			$display("running_kth_smallest_unit regression: fail");
		$finish;
	end
endmodule

// ===== sim.f =====
design/rks_pkg.sv
design/rks_if.sv
design/rks_mem.sv
design/running_kth_smallest_unit.sv
sim/running_kth_smallest_unit_tb.sv
